// File: src/mme_pkg.sv
`default_nettype none
package mme_pkg;

    // Default structure parameters.
    localparam int DEF_MAX_DIM    = 8;

    // Width of one stored matrix entry.
    localparam int ENTRY_BITS = 16;

    // Fixed field widths.
    localparam int VAL_W   = ENTRY_BITS;
    localparam int KIND_W  = 3;
    localparam int POS_W   = 3;
    localparam int DATA_W  = 24;
    localparam int PROD_W  = 2 * VAL_W;
    localparam int SUM_W   = PROD_W + 1;
    localparam int CNT_W   = 6;
    localparam int BIT_W   = 4;
    localparam int SIZE_W  = 4;

    // Input kinds.
    localparam logic [KIND_W-1:0] K_WRITE_A = 3'd0;
    localparam logic [KIND_W-1:0] K_WRITE_B = 3'd1;
    localparam logic [KIND_W-1:0] K_MUL     = 3'd2;
    localparam logic [KIND_W-1:0] K_ADD     = 3'd3;
    localparam logic [KIND_W-1:0] K_SCALAR  = 3'd4;
    localparam logic [KIND_W-1:0] K_POWER   = 3'd5;

    // Configuration register indexes.
    localparam logic CFG_MODULUS = 1'b0;
    localparam logic CFG_SIZE    = 1'b1;

    typedef enum logic [1:0] {C_IDLE, C_ISSUE, C_WAIT} t_ctl_state;

    typedef enum logic [3:0] {
        ST_WRA, ST_WRB, ST_MUL, ST_ADD, ST_SCAL, ST_PINIT, ST_PSQ,
        ST_PMUL, ST_PCOPY, ST_EMITS, ST_EMITW, ST_ERR
    } t_step;

    typedef enum logic [2:0] {
        DS_IDLE, DS_RD, DS_MUL, DS_ADD, DS_MOD, DS_WR, DS_EOUT, DS_EWAIT
    } t_dp_state;

    typedef enum logic [2:0] {P_WRITE, P_ELEM, P_MUL, P_EMIT, P_ERR} t_pass;
    typedef enum logic [1:0] {X_A, X_WORK, X_SCR, X_VAL} t_xsel;
    typedef enum logic [2:0] {Y_B, Y_WORK, Y_A, Y_ONE, Y_VAL} t_ysel;
    typedef enum logic [1:0] {D_A, D_B, D_WORK, D_SCR} t_dst;

    typedef struct packed {
        logic  start;
        t_pass pass;
        t_xsel xsel;
        t_ysel ysel;
        logic  addb;
        t_dst  dst;
    } t_dp_cmd;

    typedef struct packed {
        logic done;
        logic busy;
    } t_dp_stat;

endpackage
`default_nettype wire

// File: src/mme_ram.sv
`default_nettype none
module mme_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  wire  logic                                i_clk,
    input  wire  logic                                i_we,
    input  wire  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire  logic [WIDTH-1:0]                    i_wdata,
    input  wire  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic       [WIDTH-1:0]                    o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // One write port and one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule
`default_nettype wire

// File: src/mme_modred.sv
`default_nettype none
module mme_modred
    import mme_pkg::*;
(
    input  wire  logic             i_clk,
    input  wire  logic             i_rst_n,
    input  wire  logic             i_start,
    input  wire  logic [SUM_W-1:0] i_x,
    input  wire  logic [VAL_W-1:0] i_p,
    output logic                   o_done,
    output logic       [VAL_W-1:0] o_rem
);
    logic [SUM_W-1:0] r_x;
    logic [VAL_W-1:0] r_rem;
    logic [CNT_W-1:0] r_cnt;
    logic             r_done;
    logic [VAL_W:0]   w_trial;
    logic [VAL_W-1:0] n_rem;

    // One restoring step per cycle: bring in the next bit, subtract p if it fits.
    always_comb begin
        w_trial = {r_rem, r_x[SUM_W-1]};
        if (w_trial >= {1'b0, i_p}) begin
            n_rem = VAL_W'(w_trial - {1'b0, i_p});
        end else begin
            n_rem = w_trial[VAL_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_x   <= i_x;
                r_rem <= '0;
                r_cnt <= CNT_W'(SUM_W);
            end else if (r_cnt != '0) begin
                r_rem <= n_rem;
                r_x   <= r_x << 1;
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;
endmodule
`default_nettype wire

// File: src/mme_datapath.sv
`default_nettype none
module mme_datapath
    import mme_pkg::*;
#(
    parameter int MAX_DIM    = DEF_MAX_DIM
) (
    input  wire  logic              i_clk,
    input  wire  logic              i_rst_n,
    input  wire  logic              i_cfg_we,
    input  wire  logic              i_cfg_idx,
    input  wire  logic [VAL_W-1:0]  i_cfg_wdata,
    input  wire  logic              i_accept,
    input  wire  logic [POS_W-1:0]  i_row,
    input  wire  logic [POS_W-1:0]  i_col,
    input  wire  logic [VAL_W-1:0]  i_value,
    input  wire  t_dp_cmd           i_cmd,
    output t_dp_stat                o_stat,
    output logic                    o_m_valid,
    input  wire  logic              i_m_ready,
    output logic       [VAL_W-1:0]  o_m_element,
    output logic       [POS_W-1:0]  o_m_row,
    output logic       [POS_W-1:0]  o_m_col,
    output logic                    o_m_last,
    output logic                    o_m_error
);
    localparam int IW    = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int CELLS = MAX_DIM * MAX_DIM;
    localparam int AW    = (CELLS > 1) ? $clog2(CELLS) : 1;

    t_dp_state r_state, n_state;
    logic [VAL_W-1:0]  r_modulus;
    logic [SIZE_W-1:0] r_size;
    logic [IW-1:0]     r_row, r_col, r_i, r_j, r_k;
    logic [VAL_W-1:0]  r_value, r_acc, r_addend;
    logic [PROD_W-1:0] r_prod;
    t_pass r_pass;
    t_xsel r_xsel;
    t_ysel r_ysel;
    t_dst  r_dst;
    logic  r_addb;
    logic              r_out_valid, r_out_last, r_out_err;
    logic [VAL_W-1:0]  r_out_el;
    logic [POS_W-1:0]  r_out_row, r_out_col;
    logic              r_clearing;
    logic [AW-1:0]     r_clr_addr;

    logic [VAL_W-1:0]  w_p, w_x, w_y, w_add, w_rem;
    logic [IW-1:0]     w_nm1, w_kx, w_ry;
    logic [AW-1:0]     w_xaddr, w_yaddr, w_waddr, w_ab_waddr;
    logic              w_is_mul, w_at_end, w_beat, w_mod_done, w_wr;
    logic              w_we_a, w_we_b;
    logic [ENTRY_BITS-1:0] w_ax_q, w_ay_q, w_b_q, w_ab_wdata;
    logic [VAL_W-1:0]  w_wx_q, w_wy_q, w_sx_q;

    // Effective modulus and dimension.
    always_comb begin
        w_p = (r_modulus < VAL_W'(2)) ? VAL_W'(2) : r_modulus;
        if (r_size == '0) begin
            w_nm1 = '0;
        end else if (r_size > SIZE_W'(MAX_DIM)) begin
            w_nm1 = IW'(MAX_DIM - 1);
        end else begin
            w_nm1 = IW'(r_size - SIZE_W'(1));
        end
    end

    // Read and write addresses, row-major with a stride of MAX_DIM.
    assign w_is_mul = (r_pass == P_MUL);
    assign w_kx     = w_is_mul ? r_k : r_j;
    assign w_ry     = w_is_mul ? r_k : r_i;
    assign w_xaddr  = AW'(int'(r_i) * MAX_DIM + int'(w_kx));
    assign w_yaddr  = AW'(int'(w_ry) * MAX_DIM + int'(r_j));
    assign w_waddr  = AW'(int'(r_i) * MAX_DIM + int'(r_j));
    assign w_at_end = (r_i == w_nm1) && (r_j == w_nm1);
    assign w_wr     = (r_state == DS_WR);
    assign w_beat   = r_out_valid && i_m_ready;

    // The A and B stores take zeros from the clearing pass after reset.
    assign w_ab_wdata = r_clearing ? '0 : ENTRY_BITS'(r_acc);
    assign w_ab_waddr = r_clearing ? r_clr_addr : w_waddr;
    assign w_we_a     = r_clearing || (w_wr && r_dst == D_A);
    assign w_we_b     = r_clearing || (w_wr && r_dst == D_B);

    // Clearing pass: one entry of A and B per cycle after reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clearing) begin
            r_clr_addr <= r_clr_addr + AW'(1);
            if (r_clr_addr == AW'(CELLS - 1)) begin
                r_clearing <= 1'b0;
            end
        end
    end

    // Matrix stores; A and work are kept twice so both operands read at once.
    mme_ram #(.WIDTH(ENTRY_BITS), .DEPTH(CELLS)) u_a_x (
        .i_clk(i_clk), .i_we(w_we_a), .i_waddr(w_ab_waddr),
        .i_wdata(w_ab_wdata), .i_raddr(w_xaddr), .o_rdata(w_ax_q));
    mme_ram #(.WIDTH(ENTRY_BITS), .DEPTH(CELLS)) u_a_y (
        .i_clk(i_clk), .i_we(w_we_a), .i_waddr(w_ab_waddr),
        .i_wdata(w_ab_wdata), .i_raddr(w_yaddr), .o_rdata(w_ay_q));
    mme_ram #(.WIDTH(ENTRY_BITS), .DEPTH(CELLS)) u_b (
        .i_clk(i_clk), .i_we(w_we_b), .i_waddr(w_ab_waddr),
        .i_wdata(w_ab_wdata), .i_raddr(w_yaddr), .o_rdata(w_b_q));
    mme_ram #(.WIDTH(VAL_W), .DEPTH(CELLS)) u_work_x (
        .i_clk(i_clk), .i_we(w_wr && r_dst == D_WORK), .i_waddr(w_waddr),
        .i_wdata(r_acc), .i_raddr(w_xaddr), .o_rdata(w_wx_q));
    mme_ram #(.WIDTH(VAL_W), .DEPTH(CELLS)) u_work_y (
        .i_clk(i_clk), .i_we(w_wr && r_dst == D_WORK), .i_waddr(w_waddr),
        .i_wdata(r_acc), .i_raddr(w_yaddr), .o_rdata(w_wy_q));
    mme_ram #(.WIDTH(VAL_W), .DEPTH(CELLS)) u_scr (
        .i_clk(i_clk), .i_we(w_wr && r_dst == D_SCR), .i_waddr(w_waddr),
        .i_wdata(r_acc), .i_raddr(w_xaddr), .o_rdata(w_sx_q));

    // Operand selection.
    always_comb begin
        unique case (r_xsel)
            X_A:     w_x = VAL_W'(w_ax_q);
            X_WORK:  w_x = w_wx_q;
            X_SCR:   w_x = w_sx_q;
            X_VAL:   w_x = r_value;
            default: w_x = '0;
        endcase
        unique case (r_ysel)
            Y_B:     w_y = VAL_W'(w_b_q);
            Y_WORK:  w_y = w_wy_q;
            Y_A:     w_y = VAL_W'(w_ay_q);
            Y_ONE:   w_y = VAL_W'(1);
            Y_VAL:   w_y = r_value;
            default: w_y = '0;
        endcase
        if (w_is_mul) begin
            w_add = (r_k == '0) ? '0 : r_acc;
        end else begin
            w_add = r_addb ? VAL_W'(w_b_q) : '0;
        end
    end

    // Shared reduction unit for (x * y + addend) mod p.
    mme_modred u_modred (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(r_state == DS_ADD),
        .i_x(SUM_W'(r_prod) + SUM_W'(r_addend)), .i_p(w_p),
        .o_done(w_mod_done), .o_rem(w_rem));

    // Sequencer next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            DS_IDLE: begin
                if (i_cmd.start) begin
                    n_state = (i_cmd.pass == P_ERR) ? DS_EWAIT : DS_RD;
                end
            end
            DS_RD:   n_state = (r_pass == P_EMIT) ? DS_EOUT : DS_MUL;
            DS_MUL:  n_state = DS_ADD;
            DS_ADD:  n_state = DS_MOD;
            DS_MOD: begin
                if (w_mod_done) begin
                    n_state = (w_is_mul && r_k != w_nm1) ? DS_RD : DS_WR;
                end
            end
            DS_WR:   n_state = (r_pass == P_WRITE || w_at_end) ? DS_IDLE : DS_RD;
            DS_EOUT: n_state = DS_EWAIT;
            DS_EWAIT: begin
                if (w_beat) begin
                    n_state = r_out_last ? DS_IDLE : DS_RD;
                end
            end
            default: n_state = DS_IDLE;
        endcase
    end

    // Status towards the controller.
    always_comb begin
        o_stat.busy = (r_state != DS_IDLE) || r_clearing;
        o_stat.done = ((r_state == DS_WR) && (r_pass == P_WRITE || w_at_end)) ||
                      ((r_state == DS_EWAIT) && w_beat && r_out_last);
    end

    // Configuration registers and latched input fields.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_modulus <= VAL_W'(2);
            r_size    <= SIZE_W'(8);
        end else if (i_cfg_we) begin
            if (i_cfg_idx == CFG_MODULUS) begin
                r_modulus <= i_cfg_wdata;
            end else begin
                r_size <= i_cfg_wdata[SIZE_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_row   <= IW'(i_row);
            r_col   <= IW'(i_col);
            r_value <= i_value;
        end
    end

    // Sequencer state, counters and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= DS_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            unique case (r_state)
                DS_IDLE: begin
                    if (i_cmd.start) begin
                        r_pass <= i_cmd.pass;
                        r_xsel <= i_cmd.xsel;
                        r_ysel <= i_cmd.ysel;
                        r_addb <= i_cmd.addb;
                        r_dst  <= i_cmd.dst;
                        r_k    <= '0;
                        if (i_cmd.pass == P_WRITE) begin
                            r_i <= r_row;
                            r_j <= r_col;
                        end else begin
                            r_i <= '0;
                            r_j <= '0;
                        end
                        if (i_cmd.pass == P_ERR) begin
                            r_out_valid <= 1'b1;
                            r_out_el    <= '0;
                            r_out_row   <= '0;
                            r_out_col   <= '0;
                            r_out_last  <= 1'b1;
                            r_out_err   <= 1'b1;
                        end
                    end
                end
                DS_MUL: begin
                    r_prod   <= PROD_W'(w_x) * PROD_W'(w_y);
                    r_addend <= w_add;
                end
                DS_MOD: begin
                    if (w_mod_done) begin
                        r_acc <= w_rem;
                        if (w_is_mul && r_k != w_nm1) begin
                            r_k <= r_k + IW'(1);
                        end
                    end
                end
                DS_WR: begin
                    r_k <= '0;
                    if (r_j == w_nm1) begin
                        r_j <= '0;
                        r_i <= r_i + IW'(1);
                    end else begin
                        r_j <= r_j + IW'(1);
                    end
                end
                DS_EOUT: begin
                    r_out_valid <= 1'b1;
                    r_out_el    <= w_x;
                    r_out_row   <= POS_W'(r_i);
                    r_out_col   <= POS_W'(r_j);
                    r_out_last  <= w_at_end;
                    r_out_err   <= 1'b0;
                end
                DS_EWAIT: begin
                    if (w_beat) begin
                        r_out_valid <= 1'b0;
                        if (r_j == w_nm1) begin
                            r_j <= '0;
                            r_i <= r_i + IW'(1);
                        end else begin
                            r_j <= r_j + IW'(1);
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    assign o_m_valid   = r_out_valid;
    assign o_m_element = r_out_el;
    assign o_m_row     = r_out_row;
    assign o_m_col     = r_out_col;
    assign o_m_last    = r_out_last;
    assign o_m_error   = r_out_err;
endmodule
`default_nettype wire

// File: src/mme_ctrl.sv
`default_nettype none
module mme_ctrl
    import mme_pkg::*;
#(
    parameter int MAX_DIM = DEF_MAX_DIM
) (
    input  wire  logic              i_clk,
    input  wire  logic              i_rst_n,
    input  wire  logic              i_accept,
    input  wire  logic [KIND_W-1:0] i_kind,
    input  wire  logic [POS_W-1:0]  i_row,
    input  wire  logic [POS_W-1:0]  i_col,
    input  wire  logic [VAL_W-1:0]  i_value,
    input  wire  t_dp_stat          i_stat,
    output logic                    o_ready,
    output t_dp_cmd                 o_cmd
);
    t_ctl_state r_state, n_state;
    t_step      r_step, n_step;
    logic [BIT_W-1:0] r_bit, n_bit, w_top, w_bidx;
    logic [VAL_W-1:0] r_exp, n_exp;
    logic             w_in_range;

    // Highest set bit of the exponent.
    always_comb begin
        w_top = '0;
        for (int b = 0; b < VAL_W; b++) begin
            if (i_value[b]) begin
                w_top = BIT_W'(b);
            end
        end
    end

    assign w_in_range = ({1'b0, i_row} < (POS_W + 1)'(MAX_DIM)) &&
                        ({1'b0, i_col} < (POS_W + 1)'(MAX_DIM));
    assign w_bidx = r_bit - BIT_W'(1);

    // Next state: one datapath pass per step, the power loop walks the exponent.
    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        n_bit   = r_bit;
        n_exp   = r_exp;
        unique case (r_state)
            C_IDLE: begin
                if (i_accept) begin
                    n_exp = i_value;
                    n_bit = w_top;
                    priority case (i_kind)
                        K_WRITE_A: begin
                            n_step  = ST_WRA;
                            n_state = w_in_range ? C_ISSUE : C_IDLE;
                        end
                        K_WRITE_B: begin
                            n_step  = ST_WRB;
                            n_state = w_in_range ? C_ISSUE : C_IDLE;
                        end
                        K_MUL: begin
                            n_step  = ST_MUL;
                            n_state = C_ISSUE;
                        end
                        K_ADD: begin
                            n_step  = ST_ADD;
                            n_state = C_ISSUE;
                        end
                        K_SCALAR: begin
                            n_step  = ST_SCAL;
                            n_state = C_ISSUE;
                        end
                        K_POWER: begin
                            n_step  = (i_value == '0) ? ST_ERR : ST_PINIT;
                            n_state = C_ISSUE;
                        end
                        default: n_state = C_IDLE;
                    endcase
                end
            end
            C_ISSUE: n_state = C_WAIT;
            C_WAIT: begin
                if (i_stat.done) begin
                    n_state = C_ISSUE;
                    unique case (r_step)
                        ST_MUL, ST_ADD, ST_SCAL: n_step = ST_EMITS;
                        ST_PINIT: n_step = (r_bit == '0) ? ST_EMITW : ST_PSQ;
                        ST_PSQ:   n_step = r_exp[w_bidx] ? ST_PMUL : ST_PCOPY;
                        ST_PMUL, ST_PCOPY: begin
                            n_bit  = w_bidx;
                            n_step = (w_bidx == '0) ? ST_EMITW : ST_PSQ;
                        end
                        default: n_state = C_IDLE;
                    endcase
                end
            end
            default: n_state = C_IDLE;
        endcase
    end

    // Outputs: the pass description for the current step.
    always_comb begin
        o_ready    = (r_state == C_IDLE) && !i_stat.busy;
        o_cmd      = '0;
        o_cmd.start = (r_state == C_ISSUE);
        o_cmd.ysel = Y_ONE;
        unique case (r_step)
            ST_WRA:   begin o_cmd.pass = P_WRITE; o_cmd.xsel = X_VAL; o_cmd.dst = D_A; end
            ST_WRB:   begin o_cmd.pass = P_WRITE; o_cmd.xsel = X_VAL; o_cmd.dst = D_B; end
            ST_MUL: begin
                o_cmd.pass = P_MUL; o_cmd.xsel = X_A; o_cmd.ysel = Y_B; o_cmd.dst = D_SCR;
            end
            ST_ADD: begin
                o_cmd.pass = P_ELEM; o_cmd.xsel = X_A; o_cmd.addb = 1'b1; o_cmd.dst = D_SCR;
            end
            ST_SCAL: begin
                o_cmd.pass = P_ELEM; o_cmd.xsel = X_A; o_cmd.ysel = Y_VAL; o_cmd.dst = D_SCR;
            end
            ST_PINIT: begin o_cmd.pass = P_ELEM; o_cmd.xsel = X_A; o_cmd.dst = D_WORK; end
            ST_PSQ: begin
                o_cmd.pass = P_MUL; o_cmd.xsel = X_WORK; o_cmd.ysel = Y_WORK;
                o_cmd.dst  = D_SCR;
            end
            ST_PMUL: begin
                o_cmd.pass = P_MUL; o_cmd.xsel = X_SCR; o_cmd.ysel = Y_A; o_cmd.dst = D_WORK;
            end
            ST_PCOPY: begin o_cmd.pass = P_ELEM; o_cmd.xsel = X_SCR; o_cmd.dst = D_WORK; end
            ST_EMITS: begin o_cmd.pass = P_EMIT; o_cmd.xsel = X_SCR; end
            ST_EMITW: begin o_cmd.pass = P_EMIT; o_cmd.xsel = X_WORK; end
            ST_ERR:   begin o_cmd.pass = P_ERR; end
            default:  ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= C_IDLE;
            r_step  <= ST_WRA;
            r_bit   <= '0;
            r_exp   <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
            r_bit   <= n_bit;
            r_exp   <= n_exp;
        end
    end
endmodule
`default_nettype wire

// File: src/modular_matrix_engine.sv
// Square-matrix engine over the integers modulo p.
// Input channel (s_axis): tuser carries the kind (load A, load B, multiply,
// add, scalar multiply, power); tdata carries row, column and value. Loads
// reduce the value modulo p and store it; commands produce n*n result beats
// in row-major order on the m_axis channel, tlast on the final one, tuser
// set only on the single error beat of a power command with exponent zero.
// Configuration (modulus, size) is written through i_cfg_*, by the user
// only while idle; the block itself does not enforce this. All arithmetic
// goes through one multiplier and one bit-serial modular reducer of 33
// steps. A power command copies A into the work store, then runs a
// squaring pass per exponent bit below the top one, followed by a multiply
// pass for a set bit or a copy pass for a clear bit. A stall on m_axis
// simply holds the result beat in the output register. One item is worked
// on at a time; tready returns high when the last beat has been taken.
// Reset sets p = 2, n = 8 and clears the controller; a clearing pass then
// writes zero to A and B, with tready held low until it ends.
`default_nettype none
module modular_matrix_engine
    import mme_pkg::*;
#(
    parameter int MAX_DIM    = DEF_MAX_DIM
) (
    input  wire  logic              i_clk,
    input  wire  logic              i_rst_n,
    input  wire  logic              i_cfg_we,
    input  wire  logic              i_cfg_idx,
    input  wire  logic [VAL_W-1:0]  i_cfg_wdata,
    input  wire  logic              i_s_axis_tvalid,
    output logic                    o_s_axis_tready,
    input  wire  logic [DATA_W-1:0] i_s_axis_tdata,  // row, col, value, zero pad
    input  wire  logic [KIND_W-1:0] i_s_axis_tuser,  // kind
    output logic                    o_m_axis_tvalid,
    input  wire  logic              i_m_axis_tready,
    output logic       [DATA_W-1:0] o_m_axis_tdata,  // element, out_row, out_col, zero pad
    output logic                    o_m_axis_tlast,
    output logic       [0:0]        o_m_axis_tuser   // error
);
    t_dp_cmd          w_cmd;
    t_dp_stat         w_stat;
    logic             w_accept;
    logic [VAL_W-1:0] w_el;
    logic [POS_W-1:0] w_row, w_col;
    logic             w_err;

    assign w_accept = i_s_axis_tvalid && o_s_axis_tready;

    mme_ctrl #(.MAX_DIM(MAX_DIM)) u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_accept(w_accept),
        .i_kind(i_s_axis_tuser), .i_row(i_s_axis_tdata[2:0]),
        .i_col(i_s_axis_tdata[5:3]), .i_value(i_s_axis_tdata[21:6]),
        .i_stat(w_stat), .o_ready(o_s_axis_tready), .o_cmd(w_cmd));

    mme_datapath #(.MAX_DIM(MAX_DIM)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we),
        .i_cfg_idx(i_cfg_idx), .i_cfg_wdata(i_cfg_wdata), .i_accept(w_accept),
        .i_row(i_s_axis_tdata[2:0]), .i_col(i_s_axis_tdata[5:3]),
        .i_value(i_s_axis_tdata[21:6]), .i_cmd(w_cmd), .o_stat(w_stat),
        .o_m_valid(o_m_axis_tvalid), .i_m_ready(i_m_axis_tready),
        .o_m_element(w_el), .o_m_row(w_row), .o_m_col(w_col),
        .o_m_last(o_m_axis_tlast), .o_m_error(w_err));

    // Result beat packing.
    assign o_m_axis_tdata = {2'b00, w_col, w_row, w_el};
    assign o_m_axis_tuser = w_err;
endmodule
`default_nettype wire

// File: dv/modular_matrix_engine_test.sv
`default_nettype none
module modular_matrix_engine_test;
    import mme_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // Kinds that the block must ignore.
    localparam logic [KIND_W-1:0] K_SPARE_6 = 3'd6;
    localparam logic [KIND_W-1:0] K_SPARE_7 = 3'd7;
    localparam int CELLS        = 64;
    localparam int SETTLE       = 120;
    localparam int STALL_LIMIT  = 200000;
    localparam int HOLD_CYCLES  = 400;

    typedef longint unsigned t_mat [CELLS];

    typedef struct packed {
        logic [15:0] element;
        logic [2:0]  row;
        logic [2:0]  col;
        logic        last;
        logic        err;
    } t_entry;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_cfg_we = 1'b0;
    logic              i_cfg_idx = CFG_MODULUS;
    logic [VAL_W-1:0]  i_cfg_wdata = '0;
    logic              i_s_axis_tvalid = 1'b0;
    logic              o_s_axis_tready;
    logic [DATA_W-1:0] i_s_axis_tdata = '0;
    logic [KIND_W-1:0] i_s_axis_tuser = '0;
    logic              o_m_axis_tvalid;
    logic              i_m_axis_tready = 1'b0;
    logic [DATA_W-1:0] o_m_axis_tdata;
    logic              o_m_axis_tlast;
    logic [0:0]        o_m_axis_tuser;

    // Mirror of the block's stores and registers.
    logic [15:0] mat_a [CELLS];
    logic [15:0] mat_b [CELLS];
    logic [15:0] cur_modulus = 16'd2;
    logic [3:0]  cur_size = 4'd8;
    t_entry      pending_entries[$];

    int  mismatches = 0;
    int  quiet_cycles = 0;
    bit  steady = 1'b0;
    bit  hold_req = 1'b0;
    int  hold_count = 0;

    modular_matrix_engine dut (.*);

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    function automatic t_mat mat_product(t_mat x, t_mat y, int n, longint unsigned p);
        t_mat r;
        longint unsigned acc;
        r = x;
        for (int i = 0; i < n; i++) begin
            for (int j = 0; j < n; j++) begin
                acc = 0;
                for (int k = 0; k < n; k++) begin
                    acc = (acc + x[i*8+k] * y[k*8+j]) % p;
                end
                r[i*8+j] = acc;
            end
        end
        return r;
    endfunction

    // Works out the result entries that one accepted beat causes.
    function automatic void predict_results(logic [2:0] kind, logic [2:0] row,
                                            logic [2:0] col, logic [15:0] value);
        longint unsigned p;
        int n;
        int top;
        t_mat am, bm, res, wk;
        t_entry e;
        p = (cur_modulus < 2) ? 2 : longint'(cur_modulus);
        n = (cur_size == 0) ? 1 : (cur_size > 8) ? 8 : int'(cur_size);
        for (int c = 0; c < CELLS; c++) begin
            am[c] = mat_a[c];
            bm[c] = mat_b[c];
            res[c] = 0;
        end
        case (kind)
            K_WRITE_A: begin
                mat_a[row*8+col] = 16'(longint'(value) % p);
                return;
            end
            K_WRITE_B: begin
                mat_b[row*8+col] = 16'(longint'(value) % p);
                return;
            end
            K_MUL: res = mat_product(am, bm, n, p);
            K_ADD: begin
                for (int c = 0; c < CELLS; c++) res[c] = (am[c] + bm[c]) % p;
            end
            K_SCALAR: begin
                for (int c = 0; c < CELLS; c++) res[c] = (am[c] * value) % p;
            end
            K_POWER: begin
                if (value == 0) begin
                    e = '{element: 16'd0, row: 3'd0, col: 3'd0, last: 1'b1, err: 1'b1};
                    pending_entries = {pending_entries, e};
                    return;
                end
                // Left-to-right square and multiply, starting from A reduced.
                for (int c = 0; c < CELLS; c++) wk[c] = am[c] % p;
                top = 15;
                while (top > 0 && !value[top]) top--;
                for (int b = top - 1; b >= 0; b--) begin
                    wk = mat_product(wk, wk, n, p);
                    if (value[b]) wk = mat_product(wk, am, n, p);
                end
                res = wk;
            end
            default: return;
        endcase
        for (int i = 0; i < n; i++) begin
            for (int j = 0; j < n; j++) begin
                e.element = 16'(res[i*8+j] % p);
                e.row = 3'(i);
                e.col = 3'(j);
                e.last = (i == n - 1) && (j == n - 1);
                e.err = 1'b0;
                pending_entries = {pending_entries, e};
            end
        end
    endfunction

    task automatic report_mismatch(string what);
        $display("MISMATCH at %0t: %s", $realtime, what);
        mismatches++;
    endtask

    // Offers one beat and waits for it to be taken.
    task automatic send_item(logic [2:0] kind, logic [2:0] row, logic [2:0] col,
                             logic [15:0] value);
        @(negedge i_clk);
        if (!steady && $urandom_range(99) < 19) begin
            i_s_axis_tvalid = 1'b0;
            repeat ($urandom_range(1, 5)) @(negedge i_clk);
        end
        i_s_axis_tvalid = 1'b1;
        i_s_axis_tuser = kind;
        i_s_axis_tdata = {2'b00, value, col, row};
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        predict_results(kind, row, col, value);
    endtask

    // Stops offering and waits until every expected entry has come back.
    task automatic wait_drained();
        @(negedge i_clk);
        i_s_axis_tvalid = 1'b0;
        while (pending_entries.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_register(logic idx, logic [15:0] data);
        wait_drained();
        @(negedge i_clk);
        i_cfg_we = 1'b1;
        i_cfg_idx = idx;
        i_cfg_wdata = data;
        if (idx == CFG_MODULUS) cur_modulus = data;
        else cur_size = data[3:0];
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    function automatic logic [2:0] random_command();
        return 3'($urandom_range(K_MUL, K_POWER));
    endfunction

    // Both stores are zero after reset, whatever the defaults are.
    task automatic test_reset_defaults();
        send_item(K_ADD, 3'd0, 3'd0, 16'd0);
        send_item(K_WRITE_A, 3'd7, 3'd7, 16'd3);
        send_item(K_SCALAR, 3'd0, 3'd0, 16'd1);
    endtask

    // Field extremes, every kind and the named corner cases.
    task automatic test_directed();
        write_register(CFG_MODULUS, 16'd65521);
        send_item(K_WRITE_A, 3'd0, 3'd0, 16'hFFFF);
        send_item(K_WRITE_A, 3'd7, 3'd7, 16'd65520);
        send_item(K_WRITE_A, 3'd0, 3'd7, 16'h5AA5);
        send_item(K_WRITE_B, 3'd7, 3'd0, 16'hFFFF);
        send_item(K_WRITE_B, 3'd0, 3'd0, 16'hA55A);
        send_item(K_MUL, 3'd7, 3'd7, 16'hFFFF);
        send_item(K_SCALAR, 3'd0, 3'd0, 16'hFFFF);
        send_item(K_POWER, 3'd0, 3'd0, 16'd0);
        send_item(K_SPARE_6, 3'd5, 3'd2, 16'h1234);
        send_item(K_SPARE_7, 3'd2, 3'd5, 16'hFFFF);
        send_item(K_POWER, 3'd0, 3'd0, 16'd2);
        // Size outside the legal range, and a modulus below two.
        write_register(CFG_SIZE, 4'd0);
        send_item(K_ADD, 3'd0, 3'd0, 16'd0);
        write_register(CFG_SIZE, 4'd15);
        write_register(CFG_MODULUS, 16'd0);
        send_item(K_ADD, 3'd0, 3'd0, 16'd0);
        // A smaller modulus after loading: stored entries exceed it.
        write_register(CFG_SIZE, 4'd2);
        send_item(K_WRITE_A, 3'd1, 3'd1, 16'd60000);
        write_register(CFG_MODULUS, 16'd65535);
        send_item(K_WRITE_A, 3'd1, 3'd0, 16'd65534);
        write_register(CFG_MODULUS, 16'd7);
        send_item(K_POWER, 3'd0, 3'd0, 16'hFFFF);
        send_item(K_MUL, 3'd0, 3'd0, 16'd0);
        send_item(K_ADD, 3'd0, 3'd0, 16'd0);
        send_item(K_WRITE_B, 3'd1, 3'd1, 16'd1);
        wait_drained();
    endtask

    // Phases of random settings: matrices loaded, then commands mixed with further loads.
    task automatic test_random_phases();
        logic [15:0] m;
        logic [3:0]  sz;
        logic [15:0] v;
        logic [2:0]  kind;
        for (int ph = 0; ph < 8; ph++) begin
            steady = (ph < 2);
            case ($urandom_range(3))
                0: m = 16'd2;
                1: m = 16'd65521;
                2: m = 16'($urandom_range(2, 300));
                default: m = 16'($urandom_range(0, 65535));
            endcase
            sz = (ph == 5) ? 4'd8 : 4'($urandom_range(1, 3));
            write_register(CFG_MODULUS, m);
            write_register(CFG_SIZE, sz);
            for (int it = 0; it < 45; it++) begin
                if (it < 28 || $urandom_range(99) < 40) begin
                    kind = 3'($urandom_range(0, 1));
                    if ($urandom_range(99) < 8) kind = 3'($urandom_range(6, 7));
                    send_item(kind, 3'($urandom), 3'($urandom), 16'($urandom));
                end else begin
                    kind = random_command();
                    // Large matrices only see cheap commands.
                    if (sz == 8) kind = ($urandom_range(1)) ? K_ADD : K_SCALAR;
                    v = 16'($urandom);
                    if (kind == K_POWER) begin
                        if ($urandom_range(9) == 0) v = 16'd0;
                        else if (sz > 2) v = 16'($urandom_range(1, 300));
                    end
                    send_item(kind, 3'($urandom), 3'($urandom), v);
                end
            end
        end
        steady = 1'b0;
        wait_drained();
    endtask

    // The receiver holds off while commands keep arriving; the block backs up.
    task automatic test_back_pressure();
        write_register(CFG_SIZE, 4'd3);
        hold_req = 1'b1;
        for (int it = 0; it < 8; it++) begin
            send_item((it % 2) ? K_ADD : K_SCALAR, 3'd0, 3'd0, 16'($urandom));
        end
        wait_drained();
    endtask

    // Receiver side: random stalls, or a long counted hold-off on request.
    always @(negedge i_clk) begin
        if (hold_req) begin
            i_m_axis_tready = 1'b0;
            hold_count++;
            if (hold_count >= HOLD_CYCLES) begin
                hold_req = 1'b0;
                hold_count = 0;
            end
        end else begin
            i_m_axis_tready = steady || ($urandom_range(99) >= 19);
        end
    end

    // Checks each result beat against the oldest expectation.
    always @(posedge i_clk) begin
        t_entry want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (pending_entries.size() == 0) begin
                report_mismatch("result beat with nothing expected");
            end else begin
                want = pending_entries.pop_front();
                if (o_m_axis_tdata[15:0] !== want.element)
                    report_mismatch($sformatf("element %0d, wanted %0d",
                                              o_m_axis_tdata[15:0], want.element));
                if (o_m_axis_tdata[18:16] !== want.row)
                    report_mismatch($sformatf("row %0d, wanted %0d",
                                              o_m_axis_tdata[18:16], want.row));
                if (o_m_axis_tdata[21:19] !== want.col)
                    report_mismatch($sformatf("col %0d, wanted %0d",
                                              o_m_axis_tdata[21:19], want.col));
                if (o_m_axis_tlast !== want.last)
                    report_mismatch($sformatf("tlast %0b, wanted %0b",
                                              o_m_axis_tlast, want.last));
                if (o_m_axis_tuser[0] !== want.err)
                    report_mismatch($sformatf("error flag %0b, wanted %0b",
                                              o_m_axis_tuser[0], want.err));
            end
        end
    end

    // Watchdog on cycles in which no beat moves on either side.
    always @(posedge i_clk) begin
        if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("modular_matrix_engine_test failed");
            $finish;
        end
    end

    initial begin
        for (int c = 0; c < CELLS; c++) begin
            mat_a[c] = '0;
            mat_b[c] = '0;
        end
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        test_reset_defaults();
        test_directed();
        test_random_phases();
        test_back_pressure();
        wait_drained();
        if (mismatches == 0) begin
            $display("modular_matrix_engine_test passed");
        end else begin
            $display("modular_matrix_engine_test failed");
        end
        $finish;
    end

endmodule
`default_nettype wire
